>>> rtl/kat_pkg.sv
// Shared constants, codes and controller/datapath bundles for the key autorepeat tracker.
package kat_pkg;

  localparam int KEY_COUNT   = 4;
  localparam int MAPPED_KEYS = 4;
  localparam int NUM_KEYS    = (KEY_COUNT < MAPPED_KEYS) ? KEY_COUNT : MAPPED_KEYS;
  localparam int KEY_W       = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

  localparam int TIME_W  = 48;
  localparam int CNT_W   = $clog2(TIME_W);
  localparam int IVL_W   = 16;
  localparam int KIND_W  = 2;
  localparam int TYPE_W  = 16;
  localparam int CODE_W  = 16;
  localparam int VALUE_W = 2;
  localparam int MASK_W  = 4;

  localparam int IN_FIELDS_W = TIME_W + TYPE_W + CODE_W + VALUE_W;
  localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 3 * MASK_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [KIND_W-1:0] KIND_BEGIN = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EVENT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END   = 2'd2;

  localparam logic [TYPE_W-1:0]  EVENT_TYPE_KEY = 16'd1;
  localparam logic [CODE_W-1:0]  FIRST_CODE     = 16'd2;
  localparam logic [VALUE_W-1:0] VALUE_RELEASE  = 2'd0;
  localparam logic [VALUE_W-1:0] VALUE_PRESS    = 2'd1;

  localparam logic [IVL_W-1:0] DELAY_RESET    = 16'd350;
  localparam logic [IVL_W-1:0] INTERVAL_RESET = 16'd90;

  // Register index, taken from paddr[2].
  localparam logic REG_DELAY    = 1'b0;
  localparam logic REG_INTERVAL = 1'b1;

  typedef struct packed {
    logic             apply;
    logic             load_div;
    logic             div_step;
    logic             update;
    logic             emit;
    logic [KEY_W-1:0] key;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic out_free;
  } status_t;

endpackage

>>> rtl/kat_ctrl.sv
// Sequencer for the key autorepeat tracker: accepts beats and walks the frame-end scan.
module kat_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [kat_pkg::KIND_W-1:0]    in_kind_i,
  output logic                          in_ready_o,
  input  kat_pkg::status_t              status_i,
  output kat_pkg::cmd_t                 cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_UPDATE,
    ST_EMIT
  } state_e;

  state_e                       state_q;
  logic [kat_pkg::KEY_W-1:0]    key_q;
  logic [kat_pkg::CNT_W-1:0]    cnt_q;
  logic                         last_key;

  assign last_key   = (key_q == kat_pkg::KEY_W'(kat_pkg::KEY_COUNT - 1));
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o          = '0;
    cmd_o.key      = key_q;
    cmd_o.apply    = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.load_div = (state_q == ST_CHECK) && status_i.hit;
    cmd_o.div_step = (state_q == ST_DIV);
    cmd_o.update   = (state_q == ST_UPDATE);
    cmd_o.emit     = (state_q == ST_EMIT) && status_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      key_q   <= '0;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i && (in_kind_i == kat_pkg::KIND_END)) begin
            key_q   <= '0;
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (status_i.hit) begin
            cnt_q   <= kat_pkg::CNT_W'(kat_pkg::TIME_W - 1);
            state_q <= ST_DIV;
          end else if (last_key) begin
            state_q <= ST_EMIT;
          end else begin
            key_q <= key_q + 1'b1;
          end
        end
        ST_DIV: begin
          if (cnt_q == '0) begin
            state_q <= ST_UPDATE;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        ST_UPDATE: begin
          if (last_key) begin
            state_q <= ST_EMIT;
          end else begin
            key_q   <= key_q + 1'b1;
            state_q <= ST_CHECK;
          end
        end
        ST_EMIT: begin
          if (status_i.out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/kat_dp.sv
// Key state, repeat times, serial remainder unit and output register of the tracker.
module kat_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  kat_pkg::cmd_t                   cmd_i,
  output kat_pkg::status_t                status_o,
  input  logic [kat_pkg::KIND_W-1:0]      kind_i,
  input  logic [kat_pkg::TIME_W-1:0]      now_ms_i,
  input  logic [kat_pkg::TYPE_W-1:0]      event_type_i,
  input  logic [kat_pkg::CODE_W-1:0]      key_code_i,
  input  logic [kat_pkg::VALUE_W-1:0]     key_value_i,
  input  logic [kat_pkg::IVL_W-1:0]       delay_i,
  input  logic [kat_pkg::IVL_W-1:0]       interval_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [kat_pkg::MASK_W-1:0]      down_mask_o,
  output logic [kat_pkg::MASK_W-1:0]      pressed_mask_o,
  output logic [kat_pkg::MASK_W-1:0]      repeated_mask_o
);

  logic [kat_pkg::KEY_COUNT-1:0] held_q;
  logic [kat_pkg::KEY_COUNT-1:0] press_q;
  logic [kat_pkg::KEY_COUNT-1:0] fired_q;
  logic [kat_pkg::TIME_W-1:0]    due_q [kat_pkg::KEY_COUNT];
  logic [kat_pkg::TIME_W-1:0]    frame_q;
  logic [kat_pkg::TIME_W-1:0]    dvd_q;
  logic [kat_pkg::IVL_W-1:0]     rem_q;
  logic                          out_valid_q;
  logic [kat_pkg::MASK_W-1:0]    down_q;
  logic [kat_pkg::MASK_W-1:0]    pressed_q;
  logic [kat_pkg::MASK_W-1:0]    repeated_q;

  logic [kat_pkg::IVL_W-1:0]     step;
  logic [kat_pkg::TIME_W:0]      diff;
  logic [kat_pkg::IVL_W:0]       trial;
  logic [kat_pkg::IVL_W:0]       trial_sub;
  logic [kat_pkg::CODE_W-1:0]    code_off;
  logic                          key_ok;
  logic [kat_pkg::KEY_W-1:0]     ev_key;
  logic [kat_pkg::MASK_W-1:0]    down_m;
  logic [kat_pkg::MASK_W-1:0]    press_m;
  logic [kat_pkg::MASK_W-1:0]    fired_m;

  assign step = (interval_i == '0) ? kat_pkg::IVL_W'(1) : interval_i;

  // One subtract gives both the due test (no borrow) and the dividend.
  assign diff = {1'b0, frame_q} - {1'b0, due_q[cmd_i.key]};

  assign status_o.hit      = held_q[cmd_i.key] && !diff[kat_pkg::TIME_W];
  assign status_o.out_free = !out_valid_q || out_ready_i;

  // Restoring remainder step: one dividend bit enters per cycle.
  assign trial     = {rem_q, dvd_q[kat_pkg::TIME_W-1]};
  assign trial_sub = trial - {1'b0, step};

  assign code_off = key_code_i - kat_pkg::FIRST_CODE;
  assign key_ok   = (key_code_i >= kat_pkg::FIRST_CODE) &&
                    (code_off < kat_pkg::CODE_W'(kat_pkg::NUM_KEYS));
  assign ev_key   = code_off[kat_pkg::KEY_W-1:0];

  always_comb begin
    down_m  = '0;
    press_m = '0;
    fired_m = '0;
    for (int k = 0; k < kat_pkg::NUM_KEYS; k++) begin
      down_m[k]  = held_q[k];
      press_m[k] = press_q[k];
      fired_m[k] = fired_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= '0;
      press_q <= '0;
      fired_q <= '0;
      frame_q <= '0;
      for (int k = 0; k < kat_pkg::KEY_COUNT; k++) begin
        due_q[k] <= '0;
      end
    end else begin
      if (cmd_i.apply) begin
        if (kind_i == kat_pkg::KIND_BEGIN) begin
          frame_q <= now_ms_i;
          press_q <= '0;
          fired_q <= '0;
        end else if ((kind_i == kat_pkg::KIND_EVENT) &&
                     (event_type_i == kat_pkg::EVENT_TYPE_KEY) && key_ok) begin
          if (key_value_i == kat_pkg::VALUE_PRESS) begin
            if (!held_q[ev_key]) begin
              press_q[ev_key] <= 1'b1;
            end
            held_q[ev_key] <= 1'b1;
            due_q[ev_key]  <= frame_q + kat_pkg::TIME_W'(delay_i);
          end else if (key_value_i == kat_pkg::VALUE_RELEASE) begin
            held_q[ev_key] <= 1'b0;
          end
        end
      end
      // The next repeat time is frame - (elapsed mod step) + step.
      if (cmd_i.update) begin
        fired_q[cmd_i.key] <= 1'b1;
        due_q[cmd_i.key]   <= frame_q + kat_pkg::TIME_W'(step - rem_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_div) begin
      dvd_q <= diff[kat_pkg::TIME_W-1:0];
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[kat_pkg::TIME_W-2:0], 1'b0};
      if (!trial_sub[kat_pkg::IVL_W]) begin
        rem_q <= trial_sub[kat_pkg::IVL_W-1:0];
      end else begin
        rem_q <= trial[kat_pkg::IVL_W-1:0];
      end
    end
    if (cmd_i.emit) begin
      down_q     <= down_m;
      pressed_q  <= press_m;
      repeated_q <= fired_m;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign down_mask_o     = down_q;
  assign pressed_mask_o  = pressed_q;
  assign repeated_mask_o = repeated_q;

endmodule

>>> rtl/key_autorepeat_tracker.sv
// Top level of the key autorepeat tracker: stream ports, register port, controller and datapath.
//
//  Channel   Direction  Payload
//  s_axis    in         tuser: kind; tdata: now_ms, event_type, key_code, key_value
//  m_axis    out        tdata: down_mask, pressed_mask, repeated_mask
//  apb       in/out     reg 0 repeat_delay_ms, reg 1 repeat_interval_ms
//
// Frame begin and key event beats are applied as they are accepted. A frame end beat
// starts a scan over the keys that runs the 48-bit serial remainder unit for each held
// key whose repeat is due, to find its next repeat time, and then emits the masks.
// All key state clears at reset. While a result waits in the output register,
// new beats are still taken; only a frame end that finds it full waits for it.
module key_autorepeat_tracker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata from bit 0: now_ms[47:0], event_type[63:48], key_code[79:64], key_value[81:80]
  input  logic [kat_pkg::IN_DATA_W-1:0]        s_axis_tdata,
  // tuser from bit 0: kind[1:0]
  input  logic [kat_pkg::KIND_W-1:0]           s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // tdata from bit 0: down_mask[3:0], pressed_mask[7:4], repeated_mask[11:8]
  output logic [kat_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [kat_pkg::APB_ADDR_W-1:0]       paddr,
  input  logic [kat_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [kat_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                 pready
);

  localparam int TYPE_LO  = kat_pkg::TIME_W;
  localparam int CODE_LO  = TYPE_LO + kat_pkg::TYPE_W;
  localparam int VALUE_LO = CODE_LO + kat_pkg::CODE_W;

  logic [kat_pkg::IVL_W-1:0]  delay_q;
  logic [kat_pkg::IVL_W-1:0]  interval_q;
  logic                       wr_en;
  kat_pkg::cmd_t              cmd;
  kat_pkg::status_t           status;
  logic [kat_pkg::MASK_W-1:0] down_mask;
  logic [kat_pkg::MASK_W-1:0] pressed_mask;
  logic [kat_pkg::MASK_W-1:0] repeated_mask;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q    <= kat_pkg::DELAY_RESET;
      interval_q <= kat_pkg::INTERVAL_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        kat_pkg::REG_DELAY:    delay_q    <= pwdata[kat_pkg::IVL_W-1:0];
        kat_pkg::REG_INTERVAL: interval_q <= pwdata[kat_pkg::IVL_W-1:0];
        default:               delay_q    <= delay_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      kat_pkg::REG_DELAY:    prdata = kat_pkg::APB_DATA_W'(delay_q);
      kat_pkg::REG_INTERVAL: prdata = kat_pkg::APB_DATA_W'(interval_q);
      default:               prdata = '0;
    endcase
  end

  kat_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_kind_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  kat_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .kind_i          (s_axis_tuser),
    .now_ms_i        (s_axis_tdata[kat_pkg::TIME_W-1:0]),
    .event_type_i    (s_axis_tdata[TYPE_LO +: kat_pkg::TYPE_W]),
    .key_code_i      (s_axis_tdata[CODE_LO +: kat_pkg::CODE_W]),
    .key_value_i     (s_axis_tdata[VALUE_LO +: kat_pkg::VALUE_W]),
    .delay_i         (delay_q),
    .interval_i      (interval_q),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .down_mask_o     (down_mask),
    .pressed_mask_o  (pressed_mask),
    .repeated_mask_o (repeated_mask)
  );

  assign m_axis_tdata = kat_pkg::OUT_DATA_W'({repeated_mask, pressed_mask, down_mask});

endmodule

>>> dv/key_autorepeat_tracker_test.sv
// Self-checking testbench for the key autorepeat tracker: directed frames, config sweeps, random traffic.
module key_autorepeat_tracker_test;
  timeunit 1ns;
  timeprecision 1ps;

  import kat_pkg::*;

  localparam realtime CLK_PERIOD = 20;
  localparam int SETTLE_CYCLES = 250;
  localparam int HOLD_CYCLES = 400;
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;
  localparam logic [VALUE_W-1:0] VALUE_AUTOREPEAT = 2'd2;
  localparam logic [VALUE_W-1:0] VALUE_RESERVED = 2'd3;

  typedef struct packed {
    logic [MASK_W-1:0] repeated;
    logic [MASK_W-1:0] pressed;
    logic [MASK_W-1:0] down;
  } key_masks_t;

  logic clk_i;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  // tdata from bit 0: now_ms[47:0], event_type[63:48], key_code[79:64], key_value[81:80]
  logic [IN_DATA_W-1:0] s_axis_tdata;
  // tuser from bit 0: kind[1:0]
  logic [KIND_W-1:0] s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  // tdata from bit 0: down_mask[3:0], pressed_mask[7:4], repeated_mask[11:8]
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  key_autorepeat_tracker dut (.*);

  // Predicted state of the tracker.
  logic [IVL_W-1:0] cfg_delay = DELAY_RESET;
  logic [IVL_W-1:0] cfg_interval = INTERVAL_RESET;
  bit held [NUM_KEYS];
  bit new_press [NUM_KEYS];
  bit fired [NUM_KEYS];
  logic [TIME_W-1:0] due_ms [NUM_KEYS];
  logic [TIME_W-1:0] frame_ms;

  key_masks_t pending_masks [$];
  key_masks_t checked_masks;
  int errors;
  int live_beats;
  int hold_requests;
  bit src_eager;
  bit sink_eager;
  logic [TIME_W-1:0] clock_ms;

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  initial begin
    #(CLK_PERIOD * 4_000_000);
    $display("Verification failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    errors++;
  endtask

  // Applies one accepted beat to the predicted state. Returns 1 when it yields a result.
  function automatic bit track_beat(input logic [KIND_W-1:0] kind, input logic [TIME_W-1:0] now,
                                    input logic [TYPE_W-1:0] ev_type,
                                    input logic [CODE_W-1:0] code,
                                    input logic [VALUE_W-1:0] value,
                                    output key_masks_t masks, output bit live);
    int key;
    bit has_result;
    logic [63:0] step;
    logic [63:0] lag;
    logic [63:0] periods;
    masks = '0;
    live = 1'b1;
    has_result = 1'b0;
    key = -1;
    if (code >= FIRST_CODE && code - FIRST_CODE < NUM_KEYS) key = int'(code - FIRST_CODE);
    case (kind)
      KIND_BEGIN: begin
        frame_ms = now;
        for (int k = 0; k < NUM_KEYS; k++) begin
          new_press[k] = 1'b0;
          fired[k] = 1'b0;
        end
      end
      KIND_EVENT: begin
        if (ev_type != EVENT_TYPE_KEY || key < 0 || value > VALUE_PRESS) begin
          live = 1'b0;
        end else if (value == VALUE_PRESS) begin
          if (!held[key]) new_press[key] = 1'b1;
          held[key] = 1'b1;
          due_ms[key] = frame_ms + TIME_W'(cfg_delay);
        end else begin
          held[key] = 1'b0;
        end
      end
      KIND_END: begin
        step = (cfg_interval == 0) ? 64'd1 : 64'(cfg_interval);
        for (int k = 0; k < NUM_KEYS; k++) begin
          if (held[k] && frame_ms >= due_ms[k]) begin
            // Catch up by whole intervals so the next repeat lies strictly in the future.
            lag = frame_ms - due_ms[k];
            periods = lag / step + 1;
            fired[k] = 1'b1;
            due_ms[k] = due_ms[k] + TIME_W'(periods * step);
          end
        end
        for (int k = 0; k < NUM_KEYS; k++) begin
          masks.down[k] = held[k];
          masks.pressed[k] = new_press[k];
          masks.repeated[k] = fired[k];
        end
        has_result = 1'b1;
      end
      default: live = 1'b0;
    endcase
    return has_result;
  endfunction

  function automatic logic [TIME_W-1:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [TIME_W-1:0] now,
                           input logic [TYPE_W-1:0] ev_type, input logic [CODE_W-1:0] code,
                           input logic [VALUE_W-1:0] value);
    int gap;
    bit live;
    key_masks_t masks;
    gap = src_eager ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {{(IN_DATA_W - IN_FIELDS_W){1'b0}}, value, code, ev_type, now};
    do @(posedge clk_i); while (!s_axis_tready);
    if (track_beat(kind, now, ev_type, code, value, masks, live)) pending_masks.push_back(masks);
    if (live) live_beats++;
  endtask

  // Always moves past the current edge so the valid drop gets its own time step.
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_masks.size() != 0) @(posedge clk_i);
  endtask

  // Drains all results and lets a possible frame-end scan finish before touching registers.
  task automatic settle();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic read_reg_check(input logic idx);
    logic [APB_DATA_W-1:0] want;
    want = (idx == REG_DELAY) ? APB_DATA_W'(cfg_delay) : APB_DATA_W'(cfg_interval);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want)
      report_mismatch((idx == REG_DELAY) ? "repeat_delay_ms read" : "repeat_interval_ms read",
                      64'(prdata), 64'(want));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [IVL_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= APB_DATA_W'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_DELAY) cfg_delay = val;
    else cfg_interval = val;
    @(posedge clk_i);
    read_reg_check(idx);
  endtask

  // Mostly well-formed frames (begin, a few key events, end) with some stray beats mixed in.
  task automatic run_frames(input int target, input bit steady);
    int stop_at;
    stop_at = live_beats + target;
    while (live_beats < stop_at) begin
      if (!steady) begin
        if ($urandom_range(0, 9) == 0) src_eager = ~src_eager;
        if ($urandom_range(0, 9) == 0) sink_eager = ~sink_eager;
        if ($urandom_range(0, 19) == 0) wait_for_results();
      end
      if ($urandom_range(0, 99) < 85) begin
        case ($urandom_range(0, 19))
          0: clock_ms = rand48();
          1, 2: clock_ms += $urandom;
          3, 4, 5, 6, 7: clock_ms += $urandom_range(0, 20);
          default: clock_ms += $urandom_range(0, cfg_delay + 2 * cfg_interval + 8);
        endcase
        send_item(KIND_BEGIN, clock_ms, 16'($urandom), 16'($urandom), 2'($urandom));
        repeat ($urandom_range(0, 4)) begin
          if ($urandom_range(0, 4) != 0)
            send_item(KIND_EVENT, rand48(), EVENT_TYPE_KEY,
                      FIRST_CODE + CODE_W'($urandom_range(0, NUM_KEYS - 1)),
                      ($urandom_range(0, 4) < 3) ? VALUE_PRESS : VALUE_RELEASE);
          else
            send_item(KIND_EVENT, rand48(),
                      $urandom_range(0, 1) ? EVENT_TYPE_KEY : 16'($urandom),
                      $urandom_range(0, 1) ? FIRST_CODE + CODE_W'($urandom_range(0, 5))
                                           : 16'($urandom),
                      2'($urandom));
        end
        send_item(KIND_END, rand48(), 16'($urandom), 16'($urandom), 2'($urandom));
      end else begin
        send_item(2'($urandom), rand48(), 16'($urandom), 16'($urandom), 2'($urandom));
      end
    end
  endtask

  task automatic test_register_reset();
    read_reg_check(REG_DELAY);
    read_reg_check(REG_INTERVAL);
  endtask

  task automatic test_directed_cases();
    send_item(KIND_NONE, '1, '1, '1, '1);
    send_item(KIND_END, '0, '0, '0, '0);
    send_item(KIND_BEGIN, 48'd1000, '0, '0, '0);
    send_item(KIND_EVENT, '1, EVENT_TYPE_KEY, FIRST_CODE, VALUE_PRESS);
    send_item(KIND_EVENT, '0, EVENT_TYPE_KEY, FIRST_CODE + 16'd3, VALUE_PRESS);
    // None of these may touch any key.
    send_item(KIND_EVENT, '0, 16'hFFFF, FIRST_CODE + 16'd1, VALUE_PRESS);
    send_item(KIND_EVENT, '0, EVENT_TYPE_KEY, FIRST_CODE + 16'd4, VALUE_PRESS);
    send_item(KIND_EVENT, '0, EVENT_TYPE_KEY, 16'hFFFF, VALUE_PRESS);
    send_item(KIND_EVENT, '0, EVENT_TYPE_KEY, FIRST_CODE - 16'd1, VALUE_PRESS);
    send_item(KIND_EVENT, '0, EVENT_TYPE_KEY, FIRST_CODE + 16'd1, VALUE_AUTOREPEAT);
    send_item(KIND_EVENT, '0, EVENT_TYPE_KEY, FIRST_CODE + 16'd2, VALUE_RESERVED);
    send_item(KIND_END, '0, '0, '0, '0);
    // Back key comes due exactly now; pressing the held up key restarts its delay.
    send_item(KIND_BEGIN, 48'd1350, '0, '0, '0);
    send_item(KIND_EVENT, '0, EVENT_TYPE_KEY, FIRST_CODE, VALUE_PRESS);
    send_item(KIND_END, '0, '0, '0, '0);
    // Near the top of the time range the new repeat time wraps past zero.
    send_item(KIND_BEGIN, 48'hFFFF_FFFF_FFF0, '0, '0, '0);
    send_item(KIND_EVENT, '0, EVENT_TYPE_KEY, FIRST_CODE + 16'd3, VALUE_RELEASE);
    send_item(KIND_EVENT, '0, EVENT_TYPE_KEY, FIRST_CODE + 16'd1, VALUE_PRESS);
    send_item(KIND_END, '0, '0, '0, '0);
    send_item(KIND_BEGIN, '0, '0, '0, '0);
    send_item(KIND_EVENT, '0, EVENT_TYPE_KEY, FIRST_CODE, VALUE_RELEASE);
    send_item(KIND_END, '0, '0, '0, '0);
    settle();
  endtask

  task automatic test_config_sweep();
    logic [IVL_W-1:0] delays [7];
    logic [IVL_W-1:0] intervals [7];
    delays = '{16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd1, 16'($urandom_range(0, 600)),
               DELAY_RESET};
    intervals = '{16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd1, 16'($urandom_range(0, 200)),
                  INTERVAL_RESET};
    for (int i = 0; i < 7; i++) begin
      write_reg(REG_DELAY, delays[i]);
      write_reg(REG_INTERVAL, intervals[i]);
      run_frames(150, 1'b0);
      settle();
    end
  endtask

  // The sink stops for a long stretch while frames keep coming, so the input backs up.
  task automatic test_output_stall();
    src_eager = 1'b1;
    hold_requests <= hold_requests + 1;
    run_frames(120, 1'b1);
    src_eager = 1'b0;
    settle();
  endtask

  task automatic test_sender_pause();
    repeat (4) begin
      run_frames(40, 1'b0);
      wait_for_results();
    end
    settle();
  endtask

  task automatic test_random_traffic();
    write_reg(REG_DELAY, 16'($urandom_range(0, 400)));
    write_reg(REG_INTERVAL, 16'($urandom_range(0, 120)));
    run_frames(300, 1'b0);
    settle();
  endtask

  // Result sink: random gaps per beat, plus a long hold-off on request.
  initial begin : result_sink
    int gap;
    int hold_served;
    hold_served = 0;
    m_axis_tready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_requests != hold_served) begin
        hold_served = hold_requests;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      gap = sink_eager ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_masks.size() == 0) begin
        report_mismatch("result with nothing pending", 64'(m_axis_tdata), 64'd0);
      end else begin
        checked_masks = pending_masks.pop_front();
        if (m_axis_tdata[3:0] !== checked_masks.down)
          report_mismatch("down_mask", 64'(m_axis_tdata[3:0]), 64'(checked_masks.down));
        if (m_axis_tdata[7:4] !== checked_masks.pressed)
          report_mismatch("pressed_mask", 64'(m_axis_tdata[7:4]), 64'(checked_masks.pressed));
        if (m_axis_tdata[11:8] !== checked_masks.repeated)
          report_mismatch("repeated_mask", 64'(m_axis_tdata[11:8]),
                          64'(checked_masks.repeated));
      end
    end
  end

  initial begin
    for (int k = 0; k < NUM_KEYS; k++) due_ms[k] = '0;
    frame_ms = '0;
    clock_ms = '0;
    errors = 0;
    live_beats = 0;
    hold_requests <= 0;
    rst_ni <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_register_reset();
    test_directed_cases();
    test_config_sweep();
    test_output_stall();
    test_sender_pause();
    test_random_traffic();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
